>>> rtl/bsp_pkg.sv
// Shared types and constants for the partition tree point locator.
`timescale 1ns / 1ps

package bsp_pkg;

    // Default table size
    localparam int NODE_DEPTH_DEF = 4096;

    // Beat widths
    localparam int IN_TDATA_W  = 240;
    localparam int OUT_TDATA_W = 16;
    localparam int CNT_W       = 13;
    localparam int LINK_W      = 16;
    localparam int SUB_W       = 15;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // Child link leaf flag position
    localparam int LEAF_BIT = 15;

    // Input kind carried on tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Register word index
    localparam logic REG_NODE_COUNT = 1'b0;

    // Result status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    // One table entry as stored in the node memory
    typedef struct packed {
        logic [LINK_W-1:0] link_back;
        logic [LINK_W-1:0] link_front;
        logic [31:0]       dir_y;
        logic [31:0]       dir_x;
        logic [31:0]       org_y;
        logic [31:0]       org_x;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Walk sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MULT,
        ST_DECIDE,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/bsp_point_locator.sv
// Top level: node table, walk sequencer and stream/APB ports.
`timescale 1ns / 1ps

// A load beat (tuser 0) writes one node into the table in its accept cycle and
// gives no result; a load at an index beyond the table is dropped. A query beat
// (tuser 1) walks the tree from node node_count-1 and returns one result beat.
// Each visited node passes through the node memory read (registered), the
// stage that forms the offsets and shortcuts, and the cross-product stage
// whose compare picks the next link and issues the next read. An empty table
// or a bad root answers without a walk. The input side takes no new beat
// while a query is in flight. The table is not cleared at reset: read only
// nodes that were loaded. node_count is written over APB at address 0; the
// user must write it only while the block is idle, which the block itself
// does not enforce.
module bsp_point_locator #(
    parameter int NODE_DEPTH = bsp_pkg::NODE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [11:0] node_index, [43:12] part_x, [75:44] part_y, [107:76] part_dx,
    // [139:108] part_dy, [155:140] child_front, [171:156] child_back,
    // [203:172] query_x, [235:204] query_y, [239:236] zero
    input  logic [bsp_pkg::IN_TDATA_W-1:0] s_tdata,
    // [0] func
    input  logic                           s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [14:0] subsector_index, [15] status
    output logic [bsp_pkg::OUT_TDATA_W-1:0] m_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsp_pkg::APB_AW-1:0]     paddr,
    input  logic [bsp_pkg::APB_DW-1:0]     pwdata,
    output logic [bsp_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    import bsp_pkg::*;

    localparam int AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam logic [LINK_W:0] DEPTH_LIM = (LINK_W+1)'(NODE_DEPTH);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   node_count_reg;
    logic [CNT_W-1:0]   visits_reg, visits_next;
    logic [31:0]        qx_reg, qy_reg;
    logic [LINK_W-1:0]  front_reg, back_reg;
    logic [SUB_W-1:0]   res_idx_reg, res_idx_next;
    logic               res_err_reg, res_err_next;
    logic [SUB_W-1:0]   out_idx_reg;
    logic               out_err_reg;
    logic               m_tvalid_reg;

    logic [11:0]        in_index;
    node_t              in_node;
    logic               in_fire;
    logic               load_we;
    logic               emit_fire;
    logic [CNT_W-1:0]   root;
    logic               root_ok;
    logic [LINK_W-1:0]  next_link;
    logic               link_ok;
    logic [AW-1:0]      raddr;
    node_t              rd_node;
    logic               side_back;

    // Unpack the input beat
    assign in_index           = s_tdata[11:0];
    assign in_node.org_x      = s_tdata[43:12];
    assign in_node.org_y      = s_tdata[75:44];
    assign in_node.dir_x      = s_tdata[107:76];
    assign in_node.dir_y      = s_tdata[139:108];
    assign in_node.link_front = s_tdata[155:140];
    assign in_node.link_back  = s_tdata[171:156];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign load_we   = in_fire && (s_tuser == FUNC_LOAD)
                    && ({{(LINK_W-11){1'b0}}, in_index} < DEPTH_LIM);
    assign emit_fire = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // Root and next-link range checks
    assign root      = node_count_reg - CNT_W'(1);
    assign root_ok   = {{(LINK_W+1-CNT_W){1'b0}}, root} < DEPTH_LIM;
    assign next_link = side_back ? back_reg : front_reg;
    assign link_ok   = (next_link < {{(LINK_W-CNT_W){1'b0}}, node_count_reg})
                    && ({1'b0, next_link} < DEPTH_LIM)
                    && (visits_reg < node_count_reg);

    // Node table; a load writes before any later query can issue its read
    bsp_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (load_we),
        .waddr (AW'(in_index)),
        .wdata (in_node),
        .raddr (raddr),
        .rdata (rd_node)
    );

    bsp_side u_side (
        .aclk      (aclk),
        .node      (rd_node),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .side_back (side_back)
    );

    // Walk sequencer
    always_comb begin
        state_next   = state_reg;
        visits_next  = visits_reg;
        res_idx_next = res_idx_reg;
        res_err_next = res_err_reg;
        raddr        = AW'(root);
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_tuser == FUNC_QUERY)) begin
                    if (node_count_reg == '0) begin
                        res_idx_next = '0;
                        res_err_next = STAT_OK;
                        state_next   = ST_EMIT;
                    end else if (!root_ok) begin
                        res_idx_next = '0;
                        res_err_next = STAT_ERR;
                        state_next   = ST_EMIT;
                    end else begin
                        visits_next = CNT_W'(1);
                        state_next  = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                raddr = AW'(next_link);
                if (next_link[LEAF_BIT]) begin
                    res_idx_next = next_link[SUB_W-1:0];
                    res_err_next = STAT_OK;
                    state_next   = ST_EMIT;
                end else if (!link_ok) begin
                    res_idx_next = '0;
                    res_err_next = STAT_ERR;
                    state_next   = ST_EMIT;
                end else begin
                    visits_next = visits_reg + CNT_W'(1);
                    state_next  = ST_FETCH;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Walk payload
    always_ff @(posedge aclk) begin
        visits_reg  <= visits_next;
        res_idx_reg <= res_idx_next;
        res_err_reg <= res_err_next;
        if (in_fire) begin
            qx_reg <= s_tdata[203:172];
            qy_reg <= s_tdata[235:204];
        end
        if (state_reg == ST_FETCH) begin
            front_reg <= rd_node.link_front;
            back_reg  <= rd_node.link_back;
        end
        if (emit_fire) begin
            out_idx_reg <= res_idx_reg;
            out_err_reg <= res_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_err_reg, out_idx_reg};

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT)) begin
            node_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT)
                  ? {{(APB_DW-CNT_W){1'b0}}, node_count_reg} : '0;

endmodule

>>> rtl/bsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/bsp_side.sv
// Two-stage side test: picks front or back of one partition line for a point.
`timescale 1ns / 1ps

module bsp_side (
    input  logic           aclk,
    input  bsp_pkg::node_t node,
    input  logic [31:0]    qx,
    input  logic [31:0]    qy,
    output logic           side_back
);

    import bsp_pkg::*;

    logic [31:0]        ux;
    logic [31:0]        uy;
    logic               axis_hit;
    logic               axis_side;
    logic               sign_hit;

    logic               hit1_reg;
    logic               side1_reg;
    logic signed [31:0] ux1_reg;
    logic signed [31:0] uy1_reg;
    logic signed [15:0] dyh1_reg;
    logic signed [15:0] dxh1_reg;

    logic               hit2_reg;
    logic               side2_reg;
    logic signed [47:0] prod_l_reg;
    logic signed [47:0] prod_r_reg;
    logic signed [47:0] prod_l_next;
    logic signed [47:0] prod_r_next;

    // Stage 1: offsets from the origin and the cheap shortcuts
    always_comb begin
        ux       = qx - node.org_x;
        uy       = qy - node.org_y;
        axis_hit = (node.dir_x == 32'd0) || (node.dir_y == 32'd0);
        if (node.dir_x == 32'd0) begin
            // vertical line
            if ($signed(qx) <= $signed(node.org_x)) begin
                axis_side = $signed(node.dir_y) > 32'sd0;
            end else begin
                axis_side = node.dir_y[31];
            end
        end else begin
            // horizontal line
            if ($signed(qy) <= $signed(node.org_y)) begin
                axis_side = node.dir_x[31];
            end else begin
                axis_side = $signed(node.dir_x) > 32'sd0;
            end
        end
        sign_hit = node.dir_y[31] ^ node.dir_x[31] ^ ux[31] ^ uy[31];
    end

    always_ff @(posedge aclk) begin
        hit1_reg  <= axis_hit || sign_hit;
        side1_reg <= axis_hit ? axis_side : (node.dir_y[31] ^ ux[31]);
        ux1_reg   <= ux;
        uy1_reg   <= uy;
        dyh1_reg  <= node.dir_y[31:16];
        dxh1_reg  <= node.dir_x[31:16];
    end

    // Stage 2: the two cross products, 16 x 32 each
    assign prod_l_next = dyh1_reg * ux1_reg;
    assign prod_r_next = uy1_reg * dxh1_reg;

    always_ff @(posedge aclk) begin
        hit2_reg   <= hit1_reg;
        side2_reg  <= side1_reg;
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
    end

    // Compare the products after the >>16 scaling; right < left means front
    assign side_back = hit2_reg ? side2_reg
                     : !($signed(prod_r_reg[47:16]) < $signed(prod_l_reg[47:16]));

endmodule

>>> rtl/bsp_checker.sv
// Port-level checks for the point locator, bound to the top level.
`timescale 1ns / 1ps

module bsp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bsp_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import bsp_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // An error result carries a zero index; status sits just above the index
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[SUB_W] == STAT_ERR) |-> m_tdata[SUB_W-1:0] == '0)
        else $error("error result with nonzero index");

    // A query keeps the input side closed while it walks
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_QUERY) |=> !s_tready)
        else $error("input open right after a query");

    // A load finishes in its accept cycle
    a_load_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_LOAD) |=> s_tready)
        else $error("input closed after a load");

    // No result beat straight out of reset
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid out of reset");

endmodule

bind bsp_point_locator bsp_checker u_bsp_checker (.*);

>>> tb/tb_top.sv
// Self-checking bench for the point locator: random load/query beats vs a tree walk model.
`timescale 1ns / 1ps

module tb_top;
    import bsp_pkg::*;

    localparam int TBL_DEPTH  = NODE_DEPTH_DEF;
    localparam int RAND_ITEMS = 1250;
    localparam int IDLE_PAD   = 10;
    // Worst legal run: every query looping for the full node count, every beat
    // waiting out the longest source gap and sink stall; taken a few times over.
    localparam int CYCLE_LIMIT = 20_000_000;

    localparam logic [31:0] FIX_MIN   = 32'h8000_0000;
    localparam logic [31:0] FIX_MAX   = 32'h7FFF_FFFF;
    localparam logic [15:0] LEAF_FLAG = 16'(1 << LEAF_BIT);

    localparam logic [APB_AW-1:0] ADDR_COUNT = {REG_NODE_COUNT, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE = {~REG_NODE_COUNT, 2'b00};

    // Input beat payload, lowest field last
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] qy;
        logic [31:0] qx;
        logic [15:0] cb;
        logic [15:0] cf;
        logic [31:0] dy;
        logic [31:0] dx;
        logic [31:0] py;
        logic [31:0] px;
        logic [11:0] idx;
    } beat_t;

    typedef struct packed {
        logic  kind;
        beat_t body;
    } item_t;

    // Result beat: status on top, subsector below
    typedef struct packed {
        logic          stat;
        logic [14:0]   leaf_id;
    } sector_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = FUNC_LOAD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_AW-1:0]      paddr    = '0;
    logic [APB_DW-1:0]      pwdata   = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    // Predictor copy of the table and the count register
    node_t   node_tbl [TBL_DEPTH];
    int      tbl_count = 0;
    sector_t want_sectors[$];

    // Stimulus side bookkeeping: which entries hold data
    item_t   item_q[$];
    bit      gen_written [TBL_DEPTH];
    int      live_nodes[$];

    bit      no_idle    = 1'b0;
    int      send_gap   = 0;
    int      stall_cnt  = 0;
    int      mismatches = 0;
    int      cycle_cnt  = 0;
    sector_t seen_sector;
    sector_t due_sector;

    always #5 aclk = ~aclk;

    bsp_point_locator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    task automatic note_bad(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0d got %0d", what, want, got);
    endtask

    // Side test of one node: 1 picks the back link
    function automatic bit on_back(logic [31:0] px, logic [31:0] py, node_t n);
        logic [31:0] ux, uy;
        longint      lhs, rhs;
        if (n.dir_x == '0) begin
            if ($signed(px) <= $signed(n.org_x)) return $signed(n.dir_y) > 0;
            return $signed(n.dir_y) < 0;
        end
        if (n.dir_y == '0) begin
            if ($signed(py) <= $signed(n.org_y)) return $signed(n.dir_x) < 0;
            return $signed(n.dir_x) > 0;
        end
        ux = px - n.org_x;
        uy = py - n.org_y;
        // signs alone decide when the two products differ in sign
        if (n.dir_y[31] ^ n.dir_x[31] ^ ux[31] ^ uy[31])
            return n.dir_y[31] ^ ux[31];
        lhs = ((longint'($signed(n.dir_y)) >>> 16) * longint'($signed(ux))) >>> 16;
        rhs = (longint'($signed(uy)) * (longint'($signed(n.dir_x)) >>> 16)) >>> 16;
        return !(rhs < lhs);
    endfunction

    // Walk from the root to a leaf link
    function automatic sector_t locate_leaf(logic [31:0] px, logic [31:0] py);
        sector_t     res;
        logic [15:0] link;
        int          visits;
        node_t       n;
        res.leaf_id = '0;
        res.stat    = STAT_OK;
        if (tbl_count == 0) return res;
        link   = 16'(tbl_count - 1);
        visits = 0;
        while (!link[LEAF_BIT]) begin
            if (link >= tbl_count || link >= TBL_DEPTH || visits >= tbl_count) begin
                res.stat = STAT_ERR;
                return res;
            end
            visits++;
            n    = node_tbl[link];
            link = on_back(px, py, n) ? n.link_back : n.link_front;
        end
        res.leaf_id = link[14:0];
        return res;
    endfunction

    function automatic void absorb_beat(logic kind, beat_t b);
        if (kind == FUNC_LOAD)
            node_tbl[b.idx] = '{link_back: b.cb, link_front: b.cf, dir_y: b.dy,
                                dir_x: b.dx, org_y: b.py, org_x: b.px};
        else
            want_sectors.push_back(locate_leaf(b.qx, b.qy));
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (no_idle) return 0;
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Source: one beat in flight, refilled from item_q
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                absorb_beat(s_tuser, beat_t'(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    item_t it;
                    it = item_q.pop_front();
                    s_tuser  <= it.kind;
                    s_tdata  <= it.body;
                    s_tvalid <= 1'b1;
                    send_gap = idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink: random backpressure, compare each result beat in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_sector = m_tdata;
                if (want_sectors.size() == 0) begin
                    note_bad("result beat with none pending", -1, int'(m_tdata));
                end else begin
                    due_sector = want_sectors.pop_front();
                    if (seen_sector.leaf_id != due_sector.leaf_id)
                        note_bad("subsector_index", due_sector.leaf_id, seen_sector.leaf_id);
                    if (seen_sector.stat != due_sector.stat)
                        note_bad("status", due_sector.stat, seen_sector.stat);
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_cnt = idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("bsp_point_locator verification failed");
            $finish;
        end
    end

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_COUNT) tbl_count = int'(val[CNT_W-1:0]);
    endtask

    task automatic apb_read_check(logic [APB_AW-1:0] addr, logic [31:0] want);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata != want) note_bad("node_count readback", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Nothing queued, nothing on the bus, nothing owed
    task automatic wait_drained();
        while (item_q.size() > 0 || s_tvalid || want_sectors.size() > 0)
            @(posedge aclk);
    endtask

    // Drained, plus time for a load still being absorbed
    task automatic wait_idle();
        wait_drained();
        repeat (IDLE_PAD) @(posedge aclk);
    endtask

    function automatic beat_t rand_beat();
        beat_t b;
        b.pad = '0;
        b.idx = 12'($urandom);
        b.px  = $urandom;
        b.py  = $urandom;
        b.dx  = $urandom;
        b.dy  = $urandom;
        b.cf  = 16'($urandom);
        b.cb  = 16'($urandom);
        b.qx  = $urandom;
        b.qy  = $urandom;
        return b;
    endfunction

    function automatic logic [31:0] fix_val();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return '0;
        if (r < 14) return FIX_MIN;
        if (r < 20) return FIX_MAX;
        // within +/-16.0 so points land near origins
        if (r < 60) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        return $urandom;
    endfunction

    function automatic void note_written(int idx);
        if (!gen_written[idx]) begin
            gen_written[idx] = 1'b1;
            live_nodes.push_back(idx);
        end
    endfunction

    // Child link that never leads to an unloaded entry
    function automatic logic [15:0] pick_link(int lim);
        int r;
        int cand;
        r = $urandom_range(99);
        if (r < 30) return {1'b1, 15'($urandom)};
        if (r < 34) return 16'($urandom_range(TBL_DEPTH, 16'h7FFF));
        if (r < 40 && live_nodes.size() > 0)
            return 16'(live_nodes[$urandom_range(live_nodes.size() - 1)]);
        for (int t = 0; t < 16 && lim > 0; t++) begin
            cand = $urandom_range(lim - 1);
            if (gen_written[cand]) return 16'(cand);
        end
        return {1'b1, 15'($urandom)};
    endfunction

    task automatic push_node(int idx, logic [31:0] ox, logic [31:0] oy,
                             logic [31:0] dx, logic [31:0] dy,
                             logic [15:0] front, logic [15:0] back);
        item_t it;
        it.kind     = FUNC_LOAD;
        it.body     = rand_beat();
        it.body.idx = 12'(idx);
        it.body.px  = ox;
        it.body.py  = oy;
        it.body.dx  = dx;
        it.body.dy  = dy;
        it.body.cf  = front;
        it.body.cb  = back;
        note_written(idx);
        item_q.push_back(it);
    endtask

    task automatic push_query(logic [31:0] x, logic [31:0] y);
        item_t it;
        it.kind    = FUNC_QUERY;
        it.body    = rand_beat();
        it.body.qx = x;
        it.body.qy = y;
        item_q.push_back(it);
    endtask

    task automatic push_rand_load(int idx, int lim);
        logic [31:0] dx, dy;
        int          r;
        r  = $urandom_range(99);
        dx = fix_val();
        dy = fix_val();
        if (r < 15)      dx = '0;
        else if (r < 30) dy = '0;
        else if (r < 33) begin
            dx = '0;
            dy = '0;
        end
        // mark first so a node may point at itself
        note_written(idx);
        push_node(idx, fix_val(), fix_val(), dx, dy, pick_link(lim), pick_link(lim));
    endtask

    initial begin
        int sent;
        int cnt;
        int len;
        sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table
        push_query(FIX_MIN, FIX_MAX);
        push_query(FIX_MAX, FIX_MIN);
        // Small hand-built tree; 4095 loops on itself, node 2 links past the count
        push_node(4095, FIX_MAX, FIX_MIN, '0, '0, 16'd4095, 16'hFFFF);
        push_node(3, '0, '0, 32'h0001_0000, 32'h0001_0000, 16'd2, 16'd1);
        push_node(2, FIX_MIN, FIX_MAX, '0, FIX_MAX, LEAF_FLAG, 16'h0FFF);
        push_node(1, 32'h0002_8000, 32'hFFFF_8000, FIX_MIN, '0, 16'hFFFF, 16'd0);
        push_node(0, 32'h0001_0000, 32'h0001_0000, FIX_MAX, FIX_MIN, 16'd0, 16'h8005);
        wait_idle();
        apb_write(ADDR_SPARE, 32'd7);
        apb_write(ADDR_COUNT, 32'd4);
        apb_read_check(ADDR_COUNT, 32'd4);
        push_query('0, '0);
        push_query(FIX_MIN, FIX_MIN);
        push_query(FIX_MAX, FIX_MAX);
        push_query(32'h0003_0000, 32'h0005_0000);
        push_query(32'h0005_0000, 32'h0003_0000);
        push_query(FIX_MIN, FIX_MAX);
        push_query(32'hFFFF_0000, 32'h0001_0000);
        push_query(32'h0001_0000, 32'hFFFE_0000);
        wait_idle();
        // Full table: root loops until the visit budget runs out
        apb_write(ADDR_COUNT, 32'(TBL_DEPTH));
        apb_read_check(ADDR_COUNT, 32'(TBL_DEPTH));
        push_query('0, '0);
        wait_idle();
        push_node(4095, '0, '0, 32'h0003_0000, '0, 16'd3, 16'h7FFF);
        push_query(32'h0001_0000, 32'h0001_0000);
        push_query('0, FIX_MIN);
        wait_idle();

        // Random phases, each with its own node count
        for (int p = 0; sent < RAND_ITEMS; p++) begin
            if (p == 3)            cnt = 0;
            else if (p == 7)       cnt = TBL_DEPTH;
            else if (p == 1 || p == 5) cnt = 1;
            else if ($urandom_range(9) < 7) cnt = $urandom_range(2, 40);
            else                   cnt = $urandom_range(41, 600);
            no_idle = (p == 0) || ($urandom_range(3) == 0);

            // root and a spread of in-range nodes before the count goes live
            if (cnt > 0) begin
                push_rand_load(cnt - 1, cnt);
                repeat ($urandom_range(4, 20)) push_rand_load($urandom_range(cnt - 1), cnt);
            end
            wait_idle();
            apb_write(ADDR_COUNT, 32'(cnt));
            apb_read_check(ADDR_COUNT, 32'(cnt));

            len = (cnt == TBL_DEPTH) ? 50 : 100;
            for (int i = 0; i < len; i++) begin
                // hold the source until everything owed has come back
                if (p == 2 && i == len / 2) wait_drained();
                if ($urandom_range(99) < 35) begin
                    if (cnt > 0 && $urandom_range(99) < 70)
                        push_rand_load($urandom_range(cnt - 1), cnt);
                    else
                        push_rand_load($urandom_range(TBL_DEPTH - 1), cnt);
                end else begin
                    push_query(fix_val(), fix_val());
                end
            end
            sent += len;
            wait_idle();
        end

        if (mismatches == 0)
            $display("bsp_point_locator verification clean");
        else
            $display("bsp_point_locator verification failed");
        $finish;
    end

endmodule
